[hw/rtl/rfcf_pkg.sv]
package rfcf_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	// Verdict codes.
	localparam logic [1:0] FST_OK       = 2'd0;
	localparam logic [1:0] FST_BAD_SUM  = 2'd1;
	localparam logic [1:0] FST_MISMATCH = 2'd2;
	localparam logic [1:0] FST_SHORT    = 2'd3;

	// Frame constants.
	localparam logic [7:0] TX_LENGTH    = 8'd4;
	localparam logic [7:0] MIN_LENGTH   = 8'd5;
	localparam logic [7:0] RESET_ID     = 8'd1;

	// Register indexes.
	localparam logic REG_READER_ID = 1'b0;

	// Queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// One queued operation: either a whole transmit frame or one finished result.
	typedef struct packed {
		logic       is_tx;
		logic [7:0] rid;
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic       last;
		logic [1:0] frame_status;
		logic [7:0] status_word;
		logic [7:0] payload_length;
		logic [4:0] tag_count;
	} op_t;

endpackage

[hw/rtl/rfid_reader_command_framer_top.sv]
// Command/response framer for a serial reader module. An item with cmd high sends a
// four-byte command frame (length 4, reader id, command code, inverted byte sum) and
// makes that command the pending request. An item with cmd low carries one received
// byte of a length-prefixed response; payload bytes are passed on as they arrive when
// the id and command match the pending request, and the last byte of the frame gives
// one verdict item with the status word, payload length and tag count. Receive items
// are taken one per clock cycle while the queue has room; a send item yields four
// result items, serialized by the back end one frame byte per cycle while the output
// is taken. A four-entry queue between the classifying front end and the output
// back end lets input keep flowing while results wait, and an output register holds
// each result until it is taken. The reader id register sits at byte address 0 of the
// configuration port and resets to 1.
module rfid_reader_command_framer_top
	import rfcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  command_code,
	// Result channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  byte_value,
	output logic        last,
	output logic [1:0]  frame_status,
	output logic [7:0]  status_word,
	output logic [7:0]  payload_length,
	output logic [4:0]  tag_count,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] reader_id_q;
	logic       accept;
	logic       push;
	op_t        push_op;
	logic       pop;
	op_t        head;
	logic       not_empty;
	logic       not_full;

	// The port never stalls. Only the word at offset zero holds a register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_READER_ID) ? {24'd0, reader_id_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reader_id_q <= RESET_ID;
		end else if (psel && penable && pwrite && (paddr[2] == REG_READER_ID)) begin
			reader_id_q <= pwdata[7:0];
		end
	end

	// An item is taken whenever the queue has room, even while a result is waiting.
	assign in_ready = not_full;
	assign accept   = in_valid && not_full;

	rfcf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.rx_byte      (rx_byte),
		.command_code (command_code),
		.reader_id    (reader_id_q),
		.push         (push),
		.op           (push_op)
	);

	rfcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.not_full  (not_full)
	);

	rfcf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.not_empty      (not_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.byte_value     (byte_value),
		.last           (last),
		.frame_status   (frame_status),
		.status_word    (status_word),
		.payload_length (payload_length),
		.tag_count      (tag_count)
	);

endmodule

[hw/rtl/rfcf_front.sv]
module rfcf_front
	import rfcf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       cmd,
	input  logic [7:0] rx_byte,
	input  logic [7:0] command_code,
	input  logic [7:0] reader_id,
	output logic       push,
	output op_t        op
);

	logic [7:0] pos_q;
	logic [7:0] flen_q;
	logic [7:0] sum_q;
	logic [7:0] exp_cmd_q;
	logic       pending_q;
	logic       match_q;
	logic [7:0] status_q;

	logic [7:0] flen_n;
	logic [7:0] sum_base;
	logic       match_n;
	logic [7:0] status_n;
	logic [8:0] count;
	logic [8:0] need;
	logic       more;
	logic [7:0] plen;
	logic [1:0] fst;

	always_comb begin
		flen_n   = (pos_q == 8'd0) ? rx_byte : flen_q;
		sum_base = (pos_q == 8'd0) ? 8'd0 : sum_q;
		case (pos_q)
			8'd0:    match_n = 1'b0;
			8'd1:    match_n = pending_q && (rx_byte == reader_id);
			8'd2:    match_n = match_q && (rx_byte == exp_cmd_q);
			default: match_n = match_q;
		endcase
		case (pos_q)
			8'd0:    status_n = 8'd0;
			8'd3:    status_n = rx_byte;
			default: status_n = status_q;
		endcase
		count = {1'b0, pos_q} + 9'd1;
		need  = (flen_n == 8'd0) ? 9'd1 : {1'b0, flen_n};
		more  = count < need;

		// A length byte below five is always a short frame, whatever the header.
		if (flen_n < MIN_LENGTH) begin
			fst  = FST_SHORT;
			plen = 8'd0;
		end else begin
			plen = flen_n - MIN_LENGTH;
			if (!match_n) begin
				fst = FST_MISMATCH;
			end else if (rx_byte != ~sum_base) begin
				fst = FST_BAD_SUM;
			end else begin
				fst = FST_OK;
			end
		end
	end

	always_comb begin
		op = '0;
		push = 1'b0;
		if (cmd) begin
			op.is_tx      = 1'b1;
			op.rid        = reader_id;
			op.kind       = KIND_TX;
			op.byte_value = command_code;
			push          = accept;
		end else if (more) begin
			op.kind       = KIND_PAYLOAD;
			op.byte_value = rx_byte;
			push          = accept && (pos_q >= 8'd4) && match_n;
		end else begin
			op.kind           = KIND_VERDICT;
			op.last           = 1'b1;
			op.frame_status   = fst;
			op.status_word    = status_n;
			op.payload_length = plen;
			op.tag_count      = plen[7:3];
			push              = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			flen_q    <= '0;
			sum_q     <= '0;
			exp_cmd_q <= '0;
			pending_q <= 1'b0;
			match_q   <= 1'b0;
			status_q  <= '0;
		end else if (accept) begin
			if (cmd) begin
				exp_cmd_q <= command_code;
				pending_q <= 1'b1;
			end else begin
				flen_q   <= flen_n;
				status_q <= status_n;
				if (more) begin
					sum_q   <= sum_base + rx_byte;
					pos_q   <= count[7:0];
					match_q <= match_n;
				end else begin
					sum_q     <= sum_base;
					pos_q     <= '0;
					match_q   <= 1'b0;
					pending_q <= 1'b0;
					exp_cmd_q <= '0;
				end
			end
		end
	end

endmodule

[hw/rtl/rfcf_queue.sv]
module rfcf_queue
	import rfcf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head,
	output logic not_empty,
	output logic not_full
);

	op_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign not_empty = (count_q != '0);
	assign not_full  = (count_q != QAW'(0) + (QAW+1)'(QDEPTH));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/rfcf_back.sv]
module rfcf_back
	import rfcf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        head,
	input  logic       not_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] byte_value,
	output logic       last,
	output logic [1:0] frame_status,
	output logic [7:0] status_word,
	output logic [7:0] payload_length,
	output logic [4:0] tag_count
);

	logic [1:0] idx_q;
	logic       valid_q;
	op_t        out_q;
	logic       load;
	op_t        next_out;
	logic [7:0] tx_sum;

	assign tx_sum = TX_LENGTH + head.rid + head.byte_value;
	assign load   = !valid_q || out_ready;
	assign pop    = load && not_empty && (!head.is_tx || (idx_q == 2'd3));

	always_comb begin
		next_out = head;
		if (head.is_tx) begin
			case (idx_q)
				2'd0:    next_out.byte_value = TX_LENGTH;
				2'd1:    next_out.byte_value = head.rid;
				2'd2:    next_out.byte_value = head.byte_value;
				default: next_out.byte_value = ~tx_sum;
			endcase
			next_out.last = (idx_q == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= not_empty;
			if (not_empty && head.is_tx) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && not_empty) begin
			out_q <= next_out;
		end
	end

	assign out_valid      = valid_q;
	assign kind           = out_q.kind;
	assign byte_value     = out_q.byte_value;
	assign last           = out_q.last;
	assign frame_status   = out_q.frame_status;
	assign status_word    = out_q.status_word;
	assign payload_length = out_q.payload_length;
	assign tag_count      = out_q.tag_count;

endmodule

[tb/tb_top.sv]
module tb_top;
	import rfcf_pkg::*;

	// One input item as the block sees it on the input channel.
	typedef struct packed {
		logic       is_send;
		logic [7:0] rx;
		logic [7:0] code;
	} framer_item_t;

	// One result item, field for field as it leaves the block.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic       last;
		logic [1:0] frame_status;
		logic [7:0] status_word;
		logic [7:0] payload_length;
		logic [4:0] tag_count;
	} framer_result_t;

	// The reader id register is the only one, so it sits at byte address zero.
	localparam logic [2:0] READER_ID_ADDR = 3'(4 * REG_READER_ID);

	// Cycles without any handshake before the run is declared hung. The longest
	// correct quiet stretch is the forced receiver hold-off below, well under this.
	localparam int QUIET_LIMIT  = 3000;
	// The block holds at most a four-entry queue plus an output register, so this
	// margin is plenty for any in-flight work to surface.
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD    = 120;
	localparam int PRINT_CAP    = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic [7:0]  command_code = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  byte_value;
	logic        last;
	logic [1:0]  frame_status;
	logic [7:0]  status_word;
	logic [7:0]  payload_length;
	logic [4:0]  tag_count;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	rfid_reader_command_framer_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.rx_byte        (rx_byte),
		.command_code   (command_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.byte_value     (byte_value),
		.last           (last),
		.frame_status   (frame_status),
		.status_word    (status_word),
		.payload_length (payload_length),
		.tag_count      (tag_count),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// Items waiting to be offered, and results the framer still owes us.
	framer_item_t   stim_queue[$];
	framer_result_t due_results[$];

	// Our own copy of the framer's register and receive state.
	logic [7:0] reader_id_copy = RESET_ID;
	logic [7:0] rx_pos = 8'd0;
	logic [7:0] rx_len = 8'd0;
	logic [7:0] rx_sum = 8'd0;
	logic [7:0] want_code = 8'd0;
	logic       req_open = 1'b0;
	logic       hdr_ok = 1'b0;
	logic [7:0] rx_status = 8'd0;

	// Idling controls, set per phase by the stimulus process.
	logic send_idle_on = 1'b1;
	logic recv_idle_on = 1'b1;
	int   long_hold_len = 0;

	int items_queued = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int payload_seen = 0;
	int verdict_seen[4] = '{0, 0, 0, 0};
	int mismatch_count = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int hold_left = 0;
	logic hold_taken = 1'b0;
	int quiet_cycles = 0;
	framer_item_t   next_item;
	framer_result_t want;

	initial begin
		forever #2 clk = ~clk;
	end

	// Every mismatch goes through here. Printing is capped so that a badly broken
	// design cannot flood the log, but every mismatch is still counted.
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch: %s", what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp);
		if (got !== exp)
			report_mismatch($sformatf("result %0d field %s got %02h expected %02h",
				results_checked, name, got, exp));
	endtask

	function automatic framer_result_t make_result(input logic [1:0] k, input logic [7:0] v,
			input logic l, input logic [1:0] fs, input logic [7:0] sw, input logic [7:0] pl);
		framer_result_t r;
		r.kind = k;
		r.byte_value = v;
		r.last = l;
		r.frame_status = fs;
		r.status_word = sw;
		r.payload_length = pl;
		r.tag_count = pl[7:3];
		return r;
	endfunction

	// Works out what one accepted item makes the framer emit and advances our copy
	// of its state. A send item always yields the four transmit bytes; a received
	// byte yields a payload byte, a verdict, or nothing while the header and the
	// ignored tail of a rejected frame go by.
	function automatic void predict_framer_item(input logic is_send, input logic [7:0] b,
			input logic [7:0] code);
		logic [7:0] p;
		logic [7:0] need;
		logic [7:0] tx_sum;
		logic [8:0] count;
		logic [7:0] plen;
		logic [1:0] fst;
		if (is_send) begin
			tx_sum = TX_LENGTH + reader_id_copy + code;
			due_results.push_back(make_result(KIND_TX, TX_LENGTH, 1'b0, FST_OK, 8'd0, 8'd0));
			due_results.push_back(make_result(KIND_TX, reader_id_copy, 1'b0, FST_OK, 8'd0, 8'd0));
			due_results.push_back(make_result(KIND_TX, code, 1'b0, FST_OK, 8'd0, 8'd0));
			due_results.push_back(make_result(KIND_TX, ~tx_sum, 1'b1, FST_OK, 8'd0, 8'd0));
			want_code = code;
			req_open = 1'b1;
			return;
		end
		p = rx_pos;
		if (p == 8'd0) begin
			rx_len = b;
			rx_sum = 8'd0;
			rx_status = 8'd0;
			hdr_ok = 1'b0;
		end
		if (p == 8'd1)
			hdr_ok = req_open && (b == reader_id_copy);
		if (p == 8'd2)
			hdr_ok = hdr_ok && (b == want_code);
		if (p == 8'd3)
			rx_status = b;
		count = {1'b0, p} + 9'd1;
		// A length byte of zero closes the frame at once, just like a length of one.
		need = (rx_len != 8'd0) ? rx_len : 8'd1;
		if (count < {1'b0, need}) begin
			rx_sum = rx_sum + b;
			rx_pos = count[7:0];
			if (p >= 8'd4 && hdr_ok)
				due_results.push_back(make_result(KIND_PAYLOAD, b, 1'b0, FST_OK, 8'd0, 8'd0));
			return;
		end
		// Verdict order: short frame wins over a header mismatch, which wins over a
		// bad checksum.
		if (rx_len < MIN_LENGTH) begin
			fst = FST_SHORT;
			plen = 8'd0;
		end else begin
			plen = rx_len - MIN_LENGTH;
			if (!hdr_ok)
				fst = FST_MISMATCH;
			else if (b != ~rx_sum)
				fst = FST_BAD_SUM;
			else
				fst = FST_OK;
		end
		due_results.push_back(make_result(KIND_VERDICT, 8'd0, 1'b1, fst, rx_status, plen));
		req_open = 1'b0;
		want_code = 8'd0;
		hdr_ok = 1'b0;
		rx_pos = 8'd0;
	endfunction

	// Gap lengths for both sides, drawn from three ranges: mostly the shortest, now and then the longest.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 92)
			return $urandom_range(3, 6);
		return $urandom_range(12, 40);
	endfunction

	// The field that the block ignores for an item still gets random bits, so
	// every input bit toggles.
	task automatic push_rx(input logic [7:0] b);
		stim_queue.push_back('{1'b0, b, 8'($urandom)});
		items_queued++;
	endtask

	task automatic push_send(input logic [7:0] code);
		stim_queue.push_back('{1'b1, 8'($urandom), code});
		items_queued++;
	endtask

	// Queues one complete response frame with a random payload. The checksum is
	// right unless asked otherwise. If send_at is a byte position, a send item is
	// slipped into the middle of the frame just before that byte.
	task automatic push_response(input int plen, input logic [7:0] id, input logic [7:0] code,
			input logic [7:0] status, input bit bad_sum, input int send_at);
		logic [7:0] frame[$];
		logic [7:0] sum;
		logic [7:0] b;
		frame.push_back(8'(plen + 5));
		frame.push_back(id);
		frame.push_back(code);
		frame.push_back(status);
		for (int i = 0; i < plen; i++) begin
			b = 8'($urandom);
			frame.push_back(b);
		end
		sum = 8'd0;
		foreach (frame[i])
			sum = sum + frame[i];
		frame.push_back(bad_sum ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum);
		foreach (frame[i]) begin
			if (i == send_at)
				push_send(8'($urandom));
			push_rx(frame[i]);
		end
	endtask

	// One random exchange. Most are a request followed by its response, with the
	// occasional wrong id, wrong command, bad checksum or send in mid-frame. The
	// rest are short frames, unsolicited responses, lone sends and random frames.
	task automatic add_random_exchange();
		int pick;
		int err;
		int plen;
		int len;
		logic [7:0] code;
		logic [7:0] id;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			code = 8'($urandom);
			push_send(code);
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
			err = $urandom_range(0, 9);
			id = reader_id_copy;
			if (err == 0)
				id = id ^ 8'($urandom_range(1, 255));
			if (err == 1)
				code = code ^ 8'($urandom_range(1, 255));
			push_response(plen, id, code, 8'($urandom), err == 2,
				($urandom_range(0, 9) == 0) ? $urandom_range(1, plen + 4) : -1);
		end else if (pick < 70) begin
			len = $urandom_range(0, 4);
			push_rx(8'(len));
			for (int i = 1; i < len; i++)
				push_rx(8'($urandom));
		end else if (pick < 80) begin
			push_response($urandom_range(0, 12), reader_id_copy, 8'($urandom), 8'($urandom),
				1'b0, -1);
		end else if (pick < 90) begin
			push_send(8'($urandom));
		end else begin
			len = $urandom_range(5, 24);
			push_rx(8'(len));
			for (int i = 1; i < len; i++)
				push_rx(8'($urandom));
		end
	endtask

	// Waits at falling edges, so that the clocked processes have settled, until
	// every queued item is taken and every owed result has arrived, then lets the
	// pipeline run dry, since a mid-frame byte produces nothing to wait for.
	task automatic wait_drained();
		while (stim_queue.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic check_reader_id();
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= READER_ID_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== reader_id_copy)
			report_mismatch($sformatf("reader id reads %02h expected %02h",
				prdata[7:0], reader_id_copy));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes the reader id with a setup and an access cycle, then reads it back.
	task automatic write_reader_id(input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= READER_ID_ADDR;
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reader_id_copy = value;
		check_reader_id();
	endtask

	// Input driver. The item on the port is fed to the predictor at the edge
	// where it is taken; a new item is put up only when the slot is free, and
	// valid is assigned once per edge so it never dips between back-to-back items.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_framer_item(cmd, rx_byte, command_code);
			items_accepted++;
		end
		if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (arst_n && stim_queue.size() != 0) begin
				next_item = stim_queue.pop_front();
				in_valid <= 1'b1;
				cmd <= next_item.is_send;
				rx_byte <= next_item.rx;
				command_code <= next_item.code;
				if (send_idle_on && $urandom_range(0, 99) < 25)
					send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor. Each taken result is matched against the oldest one owed.
	// The ready side stalls at random, and once on request it holds off for a long
	// stretch that it counts itself, so the framer's internal queue fills and the
	// input side backs up.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d value %02h",
					kind, byte_value));
			end else begin
				want = due_results.pop_front();
				check_field("kind", 8'(kind), 8'(want.kind));
				check_field("byte_value", byte_value, want.byte_value);
				check_field("last", 8'(last), 8'(want.last));
				check_field("frame_status", 8'(frame_status), 8'(want.frame_status));
				check_field("status_word", status_word, want.status_word);
				check_field("payload_length", payload_length, want.payload_length);
				check_field("tag_count", 8'(tag_count), 8'(want.tag_count));
				if (want.kind == KIND_PAYLOAD)
					payload_seen++;
				if (want.kind == KIND_VERDICT)
					verdict_seen[want.frame_status]++;
			end
			results_checked++;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (long_hold_len > 0 && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = long_hold_len - 1;
			out_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else if (arst_n && recv_idle_on && $urandom_range(0, 99) < 25) begin
			recv_stall = pick_gap() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n;
		end
	end

	// Watchdog: any handshake on either channel or on the register port counts as
	// progress. A long quiet stretch means the framer has hung.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus, phase by phase. The register is only touched with the framer idle,
	// and each phase ends with the sender pausing until every result is in.
	initial begin
		logic [7:0] code;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reader_id();

		// Directed part with the reset id. An unsolicited frame first, then a
		// zero length byte, a response carrying an all-ones status, a short frame
		// of four bytes whose status byte still shows, and a bad checksum.
		push_response(0, reader_id_copy, 8'h00, 8'h00, 1'b0, -1);
		push_send(8'h00);
		push_rx(8'h00);
		push_send(8'hFF);
		push_response(1, reader_id_copy, 8'hFF, 8'hFF, 1'b0, -1);
		push_send(8'h5A);
		push_rx(8'h04);
		push_rx(reader_id_copy);
		push_rx(8'h5A);
		push_rx(8'hC3);
		push_send(8'h33);
		push_response(1, reader_id_copy, 8'h33, 8'h00, 1'b1, -1);
		wait_drained();

		// Highest id, idling on both sides.
		write_reader_id(8'hFF);
		while (items_queued < 55)
			add_random_exchange();
		wait_drained();

		// Lowest id. The sender offers back to back while the receiver is told to
		// hold off for a long stretch, which must back the input up.
		write_reader_id(8'h00);
		send_idle_on = 1'b0;
		while (items_queued < 90)
			add_random_exchange();
		long_hold_len = LONG_HOLD;
		wait_drained();

		// A random id with no idling at all, ending with a long matched frame that
		// carries several tags.
		write_reader_id(8'($urandom_range(2, 254)));
		recv_idle_on = 1'b0;
		while (items_queued < 115)
			add_random_exchange();
		code = 8'($urandom);
		push_send(code);
		push_response(24, reader_id_copy, code, 8'($urandom), 1'b0, -1);
		wait_drained();

		$display("covered %0d items and %0d results, %0d payload bytes, with reader ids %s",
			items_accepted, results_checked, payload_seen, "01, ff, 00 and one random");
		$display("verdicts: %0d ok, %0d bad checksum, %0d mismatch, %0d short; %0d mismatches",
			verdict_seen[FST_OK], verdict_seen[FST_BAD_SUM], verdict_seen[FST_MISMATCH],
			verdict_seen[FST_SHORT], mismatch_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
